@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL, empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/ftrm_pkg.sv @@
// Package for the fan tachometer: types, codes and constants.
`timescale 1ns / 1ps

package ftrm_pkg;

    localparam int NUM_CHANNELS_DEF = 5;

    localparam int COUNT_W = 24;
    localparam int RPM_W   = 16;
    localparam int NUM_W   = 40;   // count * 60000
    localparam int DEN_W   = 36;   // pulses_per_rev * elapsed
    localparam int DSH_W   = 52;   // divisor shifted up by 16
    localparam int QUO_W   = 17;   // quotient incl. overflow bit
    localparam int STEP_W  = 5;

    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_EDGE   = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_PPR     = 2'd1;
    localparam logic [1:0] REG_MIN_RPM = 2'd2;

    localparam logic [15:0] WINDOW_RST  = 16'd1000;
    localparam logic [3:0]  PPR_RST     = 4'd2;
    localparam logic [15:0] MIN_RPM_RST = 16'd300;

    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEN,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_PUSH
    } state_t;

endpackage

@@ design/fan_tach_rpm_meter_top.sv @@
// Top level of the multi-channel fan tachometer with shared divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Multi-channel fan tachometer.
// Input stream: tuser = mode (update, tach edge, query); tdata carries
// channel, now_ms and duty_nonzero. One result beat per input beat on the
// output stream: rpm_value, stalled, window_closed.
// Edge, query and non-closing update beats go from accept through the
// hand-over state to the result register. An update that closes the
// window runs every channel through one shared 24x16 multiplier and one
// restoring divider: per channel a multiply step, 17 divide steps (one
// quotient bit each, top bit flags rpm overflow) and a write-back.
// tready is high only while the sequencer is idle.
// The output register holds a finished beat while the sink stalls; the
// block may take and work one further beat meanwhile, then waits in the
// hand-over state until the output register frees up.
// Reset (rst_n low, asynchronous) clears pulse counters, latched rpm, the
// window start, the sequencer and the output, and loads register defaults
// (window 1000 ms, 2 pulses/rev, min 300 rpm).
// APB: 0x0 window_ms, 0x4 ppr (pulses per rev), 0x8 min_rpm; pready tied high.
module fan_tach_rpm_meter_top #(
    parameter int NUM_CHANNELS = ftrm_pkg::NUM_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [3:0] channel, [35:4] now_ms, [36] duty_nonzero
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] rpm_value, [16] stalled, [17] window_closed
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    // configuration registers
    logic [15:0] window_ms_reg;
    logic [3:0]  ppr_reg;
    logic [15:0] min_rpm_reg;

    // channel state
    logic [ftrm_pkg::COUNT_W-1:0] counters_reg [NUM_CHANNELS];
    logic [ftrm_pkg::RPM_W-1:0]   latched_reg  [NUM_CHANNELS];

    // sequencer
    ftrm_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] ch_idx_reg, ch_idx_next;
    logic [31:0] window_start_reg, window_start_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [ftrm_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [ftrm_pkg::NUM_W-1:0]  rem_reg, rem_next;
    logic [ftrm_pkg::DSH_W-1:0]  dsh_reg, dsh_next;
    logic [ftrm_pkg::QUO_W-1:0]  quo_reg, quo_next;
    logic [ftrm_pkg::STEP_W-1:0] step_reg, step_next;

    // pending result and output register
    logic [15:0] res_rpm_reg, res_rpm_next;
    logic        res_stalled_reg, res_stalled_next;
    logic        res_closed_reg, res_closed_next;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;

    // array write ports
    logic                         cnt_we;
    logic [ftrm_pkg::COUNT_W-1:0] cnt_wdata;
    logic                         lat_we;
    logic [ftrm_pkg::RPM_W-1:0]   lat_wdata;

    // input decode
    logic [1:0]  in_mode;
    logic [3:0]  in_channel;
    logic [31:0] in_now;
    logic        in_duty;
    logic        in_ch_ok;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [ftrm_pkg::COUNT_W-1:0] cnt_rd;
    logic [ftrm_pkg::RPM_W-1:0]   lat_rd;
    logic [31:0] elapsed;
    logic        close_win;
    logic [3:0]  ppr_eff;
    logic        div_ge;
    logic [ftrm_pkg::RPM_W-1:0] rpm_res;
    logic        cfg_wr;

    assign in_mode    = s_axis_tuser;
    assign in_channel = s_axis_tdata[3:0];
    assign in_now     = s_axis_tdata[35:4];
    assign in_duty    = s_axis_tdata[36];
    assign in_ch_ok   = ({1'b0, in_channel} < 5'(NUM_CHANNELS));
    assign in_idx     = in_channel[IDX_W-1:0];

    // one counter port, shared by edges (idle) and the close sweep
    assign rd_idx = (state_reg == ftrm_pkg::ST_IDLE) ? in_idx : ch_idx_reg;
    assign cnt_rd = counters_reg[rd_idx];
    assign lat_rd = latched_reg[in_idx];

    assign elapsed   = in_now - window_start_reg;
    assign close_win = (elapsed >= {16'b0, window_ms_reg});
    assign ppr_eff   = (ppr_reg == 4'd0) ? 4'd1 : ppr_reg;

    // restoring step: rem is below 2^40, so the subtract fits in 40 bits
    assign div_ge  = ({12'b0, rem_reg} >= dsh_reg);
    assign rpm_res = (den_reg == '0) ? '0 :
                     (quo_reg[16] ? 16'hFFFF : quo_reg[15:0]);

    assign s_axis_tready = (state_reg == ftrm_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign pready        = 1'b1;

    // APB
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (paddr[3:2])
            ftrm_pkg::REG_WINDOW:  prdata = {16'b0, window_ms_reg};
            ftrm_pkg::REG_PPR:     prdata = {28'b0, ppr_reg};
            ftrm_pkg::REG_MIN_RPM: prdata = {16'b0, min_rpm_reg};
            default:               prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg <= ftrm_pkg::WINDOW_RST;
            ppr_reg       <= ftrm_pkg::PPR_RST;
            min_rpm_reg   <= ftrm_pkg::MIN_RPM_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                ftrm_pkg::REG_WINDOW:  window_ms_reg <= pwdata[15:0];
                ftrm_pkg::REG_PPR:     ppr_reg       <= pwdata[3:0];
                ftrm_pkg::REG_MIN_RPM: min_rpm_reg   <= pwdata[15:0];
                default:               ;
            endcase
        end
    end

    // sequencer: next state and datapath
    always_comb
    begin
        state_next        = state_reg;
        ch_idx_next       = ch_idx_reg;
        window_start_next = window_start_reg;
        elapsed_next      = elapsed_reg;
        den_next          = den_reg;
        rem_next          = rem_reg;
        dsh_next          = dsh_reg;
        quo_next          = quo_reg;
        step_next         = step_reg;
        res_rpm_next      = res_rpm_reg;
        res_stalled_next  = res_stalled_reg;
        res_closed_next   = res_closed_reg;
        out_valid_next    = out_valid_reg & ~m_axis_tready;
        out_data_next     = out_data_reg;
        cnt_we            = 1'b0;
        cnt_wdata         = cnt_rd;
        lat_we            = 1'b0;
        lat_wdata         = rpm_res;

        unique case (state_reg)
            ftrm_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    res_rpm_next     = '0;
                    res_stalled_next = 1'b0;
                    res_closed_next  = 1'b0;
                    state_next       = ftrm_pkg::ST_PUSH;
                    unique case (in_mode)
                        ftrm_pkg::MODE_UPDATE:
                        begin
                            if (close_win)
                            begin
                                window_start_next = in_now;
                                elapsed_next      = elapsed;
                                ch_idx_next       = '0;
                                state_next        = ftrm_pkg::ST_DEN;
                            end
                        end
                        ftrm_pkg::MODE_EDGE:
                        begin
                            if (in_ch_ok && cnt_rd != '1)
                            begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_rd + 1'b1;
                            end
                        end
                        ftrm_pkg::MODE_QUERY:
                        begin
                            if (in_ch_ok)
                            begin
                                res_rpm_next     = lat_rd;
                                res_stalled_next = in_duty && (lat_rd < min_rpm_reg);
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ftrm_pkg::ST_DEN:
            begin
                den_next   = {32'b0, ppr_eff} * {4'b0, elapsed_reg};
                state_next = ftrm_pkg::ST_MUL;
            end

            ftrm_pkg::ST_MUL:
            begin
                // numerator in, counter cleared for the next window
                rem_next   = {16'b0, cnt_rd} * {24'b0, ftrm_pkg::MS_PER_MINUTE};
                dsh_next   = {den_reg, 16'b0};
                quo_next   = '0;
                step_next  = ftrm_pkg::LAST_STEP;
                cnt_we     = 1'b1;
                cnt_wdata  = '0;
                state_next = ftrm_pkg::ST_DIV;
            end

            ftrm_pkg::ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg[ftrm_pkg::NUM_W-1:0];
                end
                quo_next = {quo_reg[ftrm_pkg::QUO_W-2:0], div_ge};
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next = ftrm_pkg::ST_STORE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            ftrm_pkg::ST_STORE:
            begin
                lat_we = 1'b1;
                if (ch_idx_reg == LAST_IDX)
                begin
                    res_closed_next = 1'b1;
                    state_next      = ftrm_pkg::ST_PUSH;
                end
                else
                begin
                    ch_idx_next = ch_idx_reg + 1'b1;
                    state_next  = ftrm_pkg::ST_MUL;
                end
            end

            ftrm_pkg::ST_PUSH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'b0, res_closed_reg, res_stalled_reg, res_rpm_reg};
                    state_next     = ftrm_pkg::ST_IDLE;
                end
            end

            default: state_next = ftrm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ftrm_pkg::ST_IDLE;
            ch_idx_reg       <= '0;
            window_start_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ch_idx_reg       <= ch_idx_next;
            window_start_reg <= window_start_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        elapsed_reg     <= elapsed_next;
        den_reg         <= den_next;
        rem_reg         <= rem_next;
        dsh_reg         <= dsh_next;
        quo_reg         <= quo_next;
        step_reg        <= step_next;
        res_rpm_reg     <= res_rpm_next;
        res_stalled_reg <= res_stalled_next;
        res_closed_reg  <= res_closed_next;
        out_data_reg    <= out_data_next;
    end

    // channel arrays
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                counters_reg[i] <= '0;
                latched_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cnt_we)
            begin
                counters_reg[rd_idx] <= cnt_wdata;
            end
            if (lat_we)
            begin
                latched_reg[ch_idx_reg] <= lat_wdata;
            end
        end
    end

    // checks
    `ASSERT_IMPLIES(a_div_step_range, clk, rst_n,
        state_reg == ftrm_pkg::ST_DIV, step_reg <= ftrm_pkg::LAST_STEP)
    `ASSERT_NEXT(a_load_from_push, clk, rst_n,
        state_reg != ftrm_pkg::ST_PUSH && !(out_valid_reg && !m_axis_tready),
        !out_valid_reg)
    `ASSERT_NEXT(a_close_clears_counter, clk, rst_n,
        state_reg == ftrm_pkg::ST_MUL, counters_reg[ch_idx_reg] == '0)

endmodule
